// ----- hdl/bdlp_pkg.sv -----
`default_nettype none

package bdlp_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 1'b1;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RST = 16'd50;
  localparam logic [CFG_DATA_W-1:0] HOLD_MS_RST     = 16'd1000;

  // Default width of the elapsed-time counter.
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  // Button state codes as they appear on the result stream.
  typedef enum logic [1:0] {
    PS_RELEASED = 2'd0,
    PS_PRESSED  = 2'd1,
    PS_HELD     = 2'd2
  } press_state_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] hold_ms;
  } cfg_t;

  // Input item, last field in the lowest bit.
  typedef struct packed {
    logic read_ack;
    logic tick;
    logic raw_level;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic         new_data;
    press_state_e button_state;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/bdlp_cfg.sv -----
`default_nettype none

module bdlp_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bdlp_pkg::cfg_t                         cfg_o
);

  bdlp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= bdlp_pkg::DEBOUNCE_MS_RST;
      cfg_q.hold_ms     <= bdlp_pkg::HOLD_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bdlp_pkg::REG_DEBOUNCE_MS: cfg_q.debounce_ms <= cfg_data_i;
        bdlp_pkg::REG_HOLD_MS:     cfg_q.hold_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/bdlp_core.sv -----
`default_nettype none

module bdlp_core #(
  parameter int unsigned TIMER_WIDTH = bdlp_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  bdlp_pkg::in_item_t  item_i,
  input  bdlp_pkg::cfg_t      cfg_i,
  output bdlp_pkg::result_t   result_o
);

  // Comparisons run at the wider of the counter and the register width.
  localparam int unsigned CMP_W =
    (TIMER_WIDTH > bdlp_pkg::CFG_DATA_W) ? TIMER_WIDTH : bdlp_pkg::CFG_DATA_W;

  bdlp_pkg::press_state_e state_q, state_d;
  logic                   armed_q, armed_d;
  logic                   fresh_q, fresh_d;
  logic [TIMER_WIDTH-1:0] cnt_q, cnt_d;
  bdlp_pkg::result_t      result_q, result_d;

  logic                   pressed;
  logic [TIMER_WIDTH-1:0] cnt_tick;
  logic                   over_debounce;
  logic                   over_hold;
  logic                   fresh_upd;

  assign pressed  = ~item_i.raw_level;
  // The counter saturates at all ones.
  assign cnt_tick = (item_i.tick && (cnt_q != {TIMER_WIDTH{1'b1}}))
                  ? cnt_q + TIMER_WIDTH'(1) : cnt_q;
  assign over_debounce = CMP_W'(cnt_tick) > CMP_W'(cfg_i.debounce_ms);

  always_comb begin
    state_d   = state_q;
    armed_d   = armed_q;
    fresh_upd = fresh_q;
    cnt_d     = cnt_tick;
    over_hold = 1'b0;
    case (state_q)
      bdlp_pkg::PS_RELEASED, bdlp_pkg::PS_PRESSED: begin
        if ((state_q[0] != pressed) && over_debounce) begin
          state_d   = pressed ? bdlp_pkg::PS_PRESSED : bdlp_pkg::PS_RELEASED;
          fresh_upd = 1'b1;
          cnt_d     = '0;
          if (pressed) begin
            armed_d = 1'b1;
          end
        end
        // A fresh acceptance clears the counter, so the hold check then fails.
        over_hold = CMP_W'(cnt_d) > CMP_W'(cfg_i.hold_ms);
        if (pressed && armed_d && over_hold) begin
          state_d   = bdlp_pkg::PS_HELD;
          fresh_upd = 1'b1;
        end
      end
      bdlp_pkg::PS_HELD: begin
        if (!pressed && over_debounce) begin
          state_d   = bdlp_pkg::PS_RELEASED;
          fresh_upd = 1'b1;
          cnt_d     = '0;
          armed_d   = 1'b0;
        end
      end
      default: ;
    endcase
    result_d.button_state = state_d;
    result_d.new_data     = fresh_upd;
    fresh_d = item_i.read_ack ? 1'b0 : fresh_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdlp_pkg::PS_RELEASED;
      armed_q <= 1'b0;
      fresh_q <= 1'b1;
      cnt_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      armed_q <= armed_d;
      fresh_q <= fresh_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ----- hdl/button_debounce_long_press.sv -----
`default_nettype none

// Channel  Direction  Payload (lowest bit first)                Transfer when
// s_axis   in         raw_level, tick, read_ack, zero pad        tvalid & tready
// m_axis   out        button_state[1:0], new_data, zero pad      tvalid & tready
// cfg      in         index 0 debounce_ms, 1 hold_ms             cfg_we_i high
//
// One item per clock is sustained while the result stream is ready. An item is
// registered at its input transfer, processed into the result register, and leaves from there.
// The input register takes a new item whenever it is empty or its content
// moves on in the same cycle, so a stalled result blocks intake only once both registers are full.
// Reset clears the valid flags and core state: released, disarmed, new-data set, counter at zero.

module button_debounce_long_press #(
  parameter int unsigned TIMER_WIDTH = bdlp_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input stream.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [0] raw_level, [1] tick, [2] read_ack, [7:3] zero.
  input  wire logic [bdlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Result stream.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [1:0] button_state, [2] new_data, [7:3] zero.
  output logic [bdlp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned RES_W = $bits(bdlp_pkg::result_t);
  localparam int unsigned ITEM_W = $bits(bdlp_pkg::in_item_t);

  bdlp_pkg::cfg_t     cfg;
  bdlp_pkg::in_item_t item_q;
  bdlp_pkg::result_t  result;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               step;
  logic               in_xfer;

  bdlp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The item in the input register is processed when the result register
  // is free or its content leaves in this cycle.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= s_axis_tdata[ITEM_W-1:0];
    end
  end

  bdlp_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bdlp_pkg::OUT_TDATA_W - RES_W){1'b0}}, result};

endmodule

`default_nettype wire

// ----- hdl/bdlp_checker.sv -----
`default_nettype none

module bdlp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [bdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic       out_xfer;
  logic [1:0] last_state_q;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // State of the last result transferred, released after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_state_q <= bdlp_pkg::PS_RELEASED;
    end else if (out_xfer) begin
      last_state_q <= m_axis_tdata[1:0];
    end
  end

  // A stalled result keeps its value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The unused state code never shows.
  a_no_code3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("unused button state code on result");

  // Any change of state between results is flagged as new data.
  a_change_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (m_axis_tdata[1:0] != last_state_q) |-> m_axis_tdata[2])
    else $error("state change without new-data flag");

  // Held is left only through a release.
  a_held_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (last_state_q == bdlp_pkg::PS_HELD)
      |-> (m_axis_tdata[1:0] == bdlp_pkg::PS_HELD)
       || (m_axis_tdata[1:0] == bdlp_pkg::PS_RELEASED))
    else $error("held state left without release");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/button_result_scoreboard.sv -----
`timescale 1ns / 100ps

// Watches both streams and the configuration port, keeps its own copy of the
// button state and timing registers, and checks every result transfer.
module button_result_scoreboard #(
  parameter int unsigned TIMER_WIDTH = bdlp_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // [0] raw_level, [1] tick, [2] read_ack, [7:3] zero.
  input  logic [bdlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] button_state, [2] new_data, [7:3] zero.
  input  logic [bdlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  bdlp_pkg::press_state_e          button_q;
  logic                            armed_q;
  logic                            fresh_q;
  logic [TIMER_WIDTH-1:0]          elapsed_q;
  logic [bdlp_pkg::CFG_DATA_W-1:0] debounce_q;
  logic [bdlp_pkg::CFG_DATA_W-1:0] hold_q;
  bdlp_pkg::result_t               expected_results[$];
  int unsigned                     mismatches = 0;

  // Advances the button state by one sample and returns the result it shows.
  function automatic bdlp_pkg::result_t step_button(bdlp_pkg::in_item_t smp);
    logic              pressed;
    bdlp_pkg::result_t res;
    pressed = ~smp.raw_level;
    if (smp.tick && elapsed_q != '1) begin
      elapsed_q = elapsed_q + 1'b1;
    end
    if (button_q == bdlp_pkg::PS_RELEASED || button_q == bdlp_pkg::PS_PRESSED) begin
      if (((button_q == bdlp_pkg::PS_PRESSED) != pressed) && elapsed_q > debounce_q) begin
        button_q  = pressed ? bdlp_pkg::PS_PRESSED : bdlp_pkg::PS_RELEASED;
        fresh_q   = 1'b1;
        elapsed_q = '0;
        if (pressed) begin
          armed_q = 1'b1;
        end
      end
      // The arm survives a short press, so this can fire from released.
      if (pressed && armed_q && elapsed_q > hold_q) begin
        fresh_q  = 1'b1;
        button_q = bdlp_pkg::PS_HELD;
      end
    end else if (button_q == bdlp_pkg::PS_HELD) begin
      if (!pressed && elapsed_q > debounce_q) begin
        button_q  = bdlp_pkg::PS_RELEASED;
        fresh_q   = 1'b1;
        elapsed_q = '0;
        armed_q   = 1'b0;
      end
    end
    res.button_state = button_q;
    res.new_data     = fresh_q;
    if (smp.read_ack) begin
      fresh_q = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bdlp_pkg::result_t got;
    bdlp_pkg::result_t exp_res;
    if (!rst_ni) begin
      button_q   = bdlp_pkg::PS_RELEASED;
      armed_q    = 1'b0;
      fresh_q    = 1'b1;
      elapsed_q  = '0;
      debounce_q = bdlp_pkg::DEBOUNCE_MS_RST;
      hold_q     = bdlp_pkg::HOLD_MS_RST;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bdlp_pkg::REG_DEBOUNCE_MS) begin
          debounce_q = cfg_data_i;
        end else if (cfg_idx_i == bdlp_pkg::REG_HOLD_MS) begin
          hold_q = cfg_data_i;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = bdlp_pkg::result_t'(m_axis_tdata[2:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result %b arrived with nothing expected", $time, m_axis_tdata);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got.button_state !== exp_res.button_state) begin
            $display("%0t: button_state expected %0d, got %0d", $time,
                     exp_res.button_state, got.button_state);
            mismatches++;
          end
          if (got.new_data !== exp_res.new_data) begin
            $display("%0t: new_data expected %0b, got %0b", $time,
                     exp_res.new_data, got.new_data);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(
          step_button(bdlp_pkg::in_item_t'(s_axis_tdata[2:0])));
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/button_debounce_long_press_test.sv -----
`timescale 1ns / 100ps

// Top of the button debouncer test. It only makes stimulus and gives the
// verdict; all prediction and comparison lives in the scoreboard beside the
// block, which reports a failure count and the number of results still owed.
module button_debounce_long_press_test;

  localparam int unsigned TIMER_W           = 16;
  localparam int unsigned RANDOM_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE   = 130;
  localparam int unsigned LONG_STALL_CYCLES = 64;
  // Extra wait after the last owed result; this leaves a comfortable margin.
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int unsigned RUN_LIMIT_NS      = 5_000_000;

  // Timing settings visited by the random phases. They include both zeros,
  // hold below debounce (so a stale arm can jump straight to held) and the
  // reverse.
  localparam logic [bdlp_pkg::CFG_DATA_W-1:0] DEBOUNCE_LIST[5] =
    '{16'd0, 16'd2, 16'd5, 16'd1, 16'd4};
  localparam logic [bdlp_pkg::CFG_DATA_W-1:0] HOLD_LIST[5] =
    '{16'd0, 16'd6, 16'd3, 16'd0, 16'd12};

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  // [0] raw_level, [1] tick, [2] read_ack, [7:3] zero.
  logic [bdlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // [1:0] button_state, [2] new_data, [7:3] zero.
  logic [bdlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_we_i;
  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  int unsigned                      fail_count;
  int unsigned                      pending;

  // Idle behavior of both sides, in percent of cycles.
  int unsigned                      sender_idle_pct;
  int unsigned                      rx_stall_pct;
  logic                             long_stall_req;

  // Timing currently programmed, used to size the random press lengths.
  logic [bdlp_pkg::CFG_DATA_W-1:0]  debounce_set;
  logic [bdlp_pkg::CFG_DATA_W-1:0]  hold_set;

  button_debounce_long_press #(
    .TIMER_WIDTH(TIMER_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  button_result_scoreboard #(
    .TIMER_WIDTH(TIMER_W)
  ) u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side. Each cycle the ready line is redrawn from the current stall
  // rate. When a long stall is requested the receiver holds off once on its
  // own while the sender keeps offering transfers, so both internal registers
  // fill and the input side has to stall.
  initial begin
    logic stall_done;
    stall_done    = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req && !stall_done) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Offers one sample and returns at the edge where it is transferred. The
  // gap before it is geometric, so the idle share matches the percentage.
  // The valid line is only lowered when an idle gap follows, so
  // back-to-back samples never see it dropped and raised in the same step.
  task automatic send_sample(input logic raw, input logic tick, input logic ack);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(bdlp_pkg::IN_TDATA_W - 3){1'b0}}, ack, tick, raw};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_run(input logic raw, input logic tick, input logic ack,
                          input int unsigned count);
    repeat (count) send_sample(raw, tick, ack);
  endtask

  // Stops offering samples and waits until every owed result has been
  // transferred, then lets the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Programs both timing registers, always from an idle block.
  task automatic set_timing(input logic [bdlp_pkg::CFG_DATA_W-1:0] debounce,
                            input logic [bdlp_pkg::CFG_DATA_W-1:0] hold);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bdlp_pkg::REG_DEBOUNCE_MS;
    cfg_data_i <= debounce;
    @(posedge clk_i);
    cfg_idx_i  <= bdlp_pkg::REG_HOLD_MS;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    debounce_set = debounce;
    hold_set     = hold;
  endtask

  // Random but realistic button activity: the line mostly sits at one level
  // for long enough to pass the debounce and sometimes the hold time, with
  // short bounces and a little pure noise mixed in. Ticks arrive on most
  // samples and software acknowledges now and then.
  task automatic random_stretch(input int unsigned count);
    int unsigned sent;
    int unsigned run;
    int unsigned span;
    logic        level;
    logic        raw;
    span = (debounce_set + hold_set + 3) * 4 / 3 + 2;
    if (span > 60) begin
      span = 60;
    end
    level = $urandom_range(0, 1);
    sent  = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 80) begin
        level = ~level;
      end
      if ($urandom_range(0, 99) < 20) begin
        run = $urandom_range(1, 2);
      end else begin
        run = $urandom_range(1, span);
      end
      repeat (run) begin
        raw = ($urandom_range(0, 99) < 5) ? 1'($urandom_range(0, 1)) : level;
        send_sample(raw, $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 30);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = bdlp_pkg::REG_DEBOUNCE_MS;
    cfg_data_i      = '0;
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    long_stall_req  = 1'b0;
    debounce_set    = bdlp_pkg::DEBOUNCE_MS_RST;
    hold_set        = bdlp_pkg::HOLD_MS_RST;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First the reset state: released with new-data set, an
    // acknowledge that clears the flag only after it has been shown, and a
    // press that the default debounce time rejects.
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);

    // A debounced press that is then kept down long enough to become held.
    // A release leaves held even without a tick, as the counter is already past
    // the debounce time, and it disarms the hold detection.
    set_timing(16'd2, 16'd4);
    send_run(1'b0, 1'b1, 1'b0, 3);
    send_run(1'b0, 1'b1, 1'b1, 6);
    send_sample(1'b1, 1'b0, 1'b0);
    send_run(1'b1, 1'b1, 1'b0, 3);

    // A short press leaves the arm set. With hold shorter than debounce the
    // next press then goes from released directly to held.
    set_timing(16'd1, 16'd10);
    send_run(1'b0, 1'b1, 1'b0, 2);
    send_run(1'b1, 1'b1, 1'b0, 2);
    set_timing(16'd3, 16'd0);
    send_sample(1'b0, 1'b1, 1'b1);

    // Zero debounce: the release passes even without a tick, since the counter already exceeds it.
    set_timing(16'd0, 16'd0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);

    // Largest timing values: a few ticks leave the counter far below them,
    // so a press is not let through.
    set_timing(16'hFFFE, 16'hFFFE);
    send_run(1'b0, 1'b1, 1'b1, 4);

    // Random phases, cycling through the idle modes and timing settings.
    // The first phase also gets the long receiver hold-off while the sender
    // runs flat out. Halfway through every phase the sender pauses until
    // the block has delivered everything it owes.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          rx_stall_pct    = 0;
        end
        1: begin
          sender_idle_pct = 76;
          rx_stall_pct    = 0;
        end
        2: begin
          sender_idle_pct = 0;
          rx_stall_pct    = 76;
        end
        default: begin
          sender_idle_pct = 10;
          rx_stall_pct    = 10;
        end
      endcase
      set_timing(DEBOUNCE_LIST[p % 5], HOLD_LIST[p % 5]);
      if (p == 0) begin
        long_stall_req = 1'b1;
      end
      random_stretch(ITEMS_PER_PHASE / 2);
      wait_idle();
      random_stretch(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
